/* src/rrss_pkg.sv */
// rrss_pkg.sv: shared types, codes and helpers of the round-robin slice scheduler
package rrss_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_LOADED   = 3'd0;
    localparam logic [2:0] KIND_SLICE    = 3'd1;
    localparam logic [2:0] KIND_ALL_DONE = 3'd2;
    localparam logic [2:0] KIND_STATS    = 3'd3;
    localparam logic [2:0] KIND_FULL     = 3'd4;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    // input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] arrival;
        logic [15:0] burst_len;
        logic [3:0]  process_select;
    } rrss_in_t;

    // result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  process_number;
        logic [31:0] slice_start;
        logic [31:0] slice_end;
        logic        finished;
        logic [31:0] waiting_total;
        logic [31:0] turnaround;
    } rrss_out_t;

    // one process table entry
    typedef struct packed {
        logic [31:0] ready_time;
        logic [15:0] original_arrival;
        logic [15:0] total_burst;
        logic [15:0] remaining_burst;
        logic [31:0] wait_accum;
        logic        done_flag;
    } rrss_entry_t;

    // what the datapath should place in the result register
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_LOADED,
        EMIT_FULL,
        EMIT_ALL_DONE,
        EMIT_SLICE,
        EMIT_STATS,
        EMIT_STATS_NONE
    } rrss_emit_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_UPD_START,
        ST_UPD_END,
        ST_UPD_WRITE,
        ST_RD_WAIT
    } rrss_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       clear;
        logic       scan_start;
        logic       scan_step;
        logic       upd_start;
        logic       upd_end;
        logic       upd_write;
        logic       rd_issue;
        rrss_emit_t emit;
    } rrss_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic table_full;
        logic count_zero;
        logic scan_last;
        logic found;
        logic sel_valid;
    } rrss_status_t;

    // saturating 32-bit add
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

/* src/rrss_ctrl.sv */
// rrss_ctrl.sv: command sequencer of the slice scheduler
module rrss_ctrl
    import rrss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   cmd,
    input  rrss_status_t status,
    output rrss_cmd_t    dp_cmd,
    output logic         busy
);

    rrss_state_t state_reg;
    rrss_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        dp_cmd.emit = EMIT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_LOAD:
                        begin
                            if (status.table_full)
                            begin
                                dp_cmd.emit = EMIT_FULL;
                            end
                            else
                            begin
                                dp_cmd.load = 1'b1;
                                dp_cmd.emit = EMIT_LOADED;
                            end
                        end
                        CMD_RUN:
                        begin
                            if (status.count_zero)
                            begin
                                dp_cmd.emit = EMIT_ALL_DONE;
                            end
                            else
                            begin
                                dp_cmd.scan_start = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_READ:
                        begin
                            if (status.sel_valid)
                            begin
                                dp_cmd.rd_issue = 1'b1;
                                state_next = ST_RD_WAIT;
                            end
                            else
                            begin
                                dp_cmd.emit = EMIT_STATS_NONE;
                            end
                        end
                        default:
                        begin
                            dp_cmd.clear = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                dp_cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL:
            begin
                state_next = ST_UPD_START;
            end
            ST_UPD_START:
            begin
                if (status.found)
                begin
                    dp_cmd.upd_start = 1'b1;
                    state_next = ST_UPD_END;
                end
                else
                begin
                    dp_cmd.emit = EMIT_ALL_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_UPD_END:
            begin
                dp_cmd.upd_end = 1'b1;
                state_next = ST_UPD_WRITE;
            end
            ST_UPD_WRITE:
            begin
                dp_cmd.upd_write = 1'b1;
                dp_cmd.emit = EMIT_SLICE;
                state_next = ST_IDLE;
            end
            ST_RD_WAIT:
            begin
                dp_cmd.emit = EMIT_STATS;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* src/rrss_datapath.sv */
// rrss_datapath.sv: process table memory, scan, slice arithmetic and result register
module rrss_datapath
    import rrss_pkg::*;
#(
    parameter int PROC_MAX = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  rrss_in_t     request,
    input  logic         quantum_we,
    input  logic [15:0]  quantum_data,
    input  rrss_cmd_t    dp_cmd,
    output rrss_status_t status,
    output logic         result_valid,
    output rrss_out_t    result
);

    localparam int IW = (PROC_MAX > 1) ? $clog2(PROC_MAX) : 1;
    localparam int CW = $clog2(PROC_MAX + 1);

    // process table
    rrss_entry_t mem [PROC_MAX];
    rrss_entry_t rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    rrss_entry_t   wr_data;

    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   clock_reg, clock_next;
    logic [15:0]   quantum_reg;
    logic [IW-1:0] scan_ptr_reg, scan_ptr_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    rrss_entry_t   best_reg, best_next;
    logic [31:0]   start_reg, start_next;
    logic [31:0]   end_reg, end_next;
    logic [15:0]   run_reg, run_next;
    logic          res_valid_reg, res_valid_next;
    rrss_out_t     res_reg, res_next;

    logic [15:0]   q_eff;
    logic          take;
    logic          fin;
    logic [31:0]   slice_end;
    rrss_entry_t   load_entry;

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_addr = dp_cmd.rd_issue ? IW'(request.process_select) : scan_ptr_reg;

    always_comb
    begin
        load_entry = '0;
        load_entry.ready_time       = {16'd0, request.arrival};
        load_entry.original_arrival = request.arrival;
        load_entry.total_burst      = request.burst_len;
        load_entry.remaining_burst  = request.burst_len;
    end

    assign wr_en   = dp_cmd.load | dp_cmd.upd_write;
    assign wr_addr = dp_cmd.load ? IW'(count_reg) : best_idx_reg;
    assign wr_data = dp_cmd.load ? load_entry : best_reg;

    // status towards the controller
    assign status.table_full = (count_reg == CW'(PROC_MAX));
    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = (CW'(scan_ptr_reg) == count_reg - CW'(1));
    assign status.found      = found_reg;
    assign status.sel_valid  = (32'(request.process_select) < 32'(count_reg));

    // quantum of zero runs as one
    assign q_eff = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;

    // earliest ready time wins, then earlier arrival, then lower slot
    assign take = pend_reg && !rd_data_reg.done_flag &&
                  (!found_reg ||
                   (rd_data_reg.ready_time < best_reg.ready_time) ||
                   ((rd_data_reg.ready_time == best_reg.ready_time) &&
                    (rd_data_reg.original_arrival < best_reg.original_arrival)));

    assign fin       = (best_reg.remaining_burst <= q_eff);
    assign slice_end = sat_add32(start_reg, {16'd0, run_reg});

    // next state of the datapath registers
    always_comb
    begin
        count_next    = count_reg;
        clock_next    = clock_reg;
        scan_ptr_next = scan_ptr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        run_next      = run_reg;

        // table load and clear
        if (dp_cmd.load)
        begin
            count_next = count_reg + CW'(1);
        end
        if (dp_cmd.clear)
        begin
            count_next = '0;
            clock_next = '0;
        end

        // slot of a statistics read, held until its result is built
        if (dp_cmd.rd_issue)
        begin
            pend_idx_next = IW'(request.process_select);
        end

        // scan pipeline: read issue then compare
        if (take)
        begin
            found_next    = 1'b1;
            best_idx_next = pend_idx_reg;
            best_next     = rd_data_reg;
        end
        if (dp_cmd.scan_start)
        begin
            scan_ptr_next = '0;
            found_next    = 1'b0;
        end
        if (dp_cmd.scan_step)
        begin
            pend_next     = 1'b1;
            pend_idx_next = scan_ptr_reg;
            scan_ptr_next = scan_ptr_reg + IW'(1);
        end

        // slice: start time, run length and remaining burst
        if (dp_cmd.upd_start)
        begin
            start_next = (clock_reg < best_reg.ready_time) ? best_reg.ready_time : clock_reg;
            run_next   = fin ? best_reg.remaining_burst : q_eff;
            best_next.remaining_burst = fin ? 16'd0 : best_reg.remaining_burst - q_eff;
            best_next.done_flag       = fin;
        end

        // slice: waiting time, end time and clock
        if (dp_cmd.upd_end)
        begin
            best_next.wait_accum = sat_add32(best_reg.wait_accum,
                                             start_reg - best_reg.ready_time);
            end_next   = slice_end;
            clock_next = slice_end;
            if (!best_reg.done_flag)
            begin
                best_next.ready_time = slice_end;
            end
        end
    end

    // result register
    always_comb
    begin
        res_valid_next = (dp_cmd.emit != EMIT_NONE);
        res_next       = '0;
        case (dp_cmd.emit)
            EMIT_LOADED:
            begin
                res_next.kind           = KIND_LOADED;
                res_next.process_number = 5'(32'(count_reg) + 32'd1);
            end
            EMIT_FULL:
            begin
                res_next.kind = KIND_FULL;
            end
            EMIT_ALL_DONE:
            begin
                res_next.kind        = KIND_ALL_DONE;
                res_next.slice_start = clock_reg;
                res_next.slice_end   = clock_reg;
            end
            EMIT_SLICE:
            begin
                res_next.kind           = KIND_SLICE;
                res_next.process_number = 5'(32'(best_idx_reg) + 32'd1);
                res_next.slice_start    = start_reg;
                res_next.slice_end      = end_reg;
                res_next.finished       = best_reg.done_flag;
                res_next.waiting_total  = best_reg.wait_accum;
                res_next.turnaround     = sat_add32(best_reg.wait_accum,
                                                    {16'd0, best_reg.total_burst});
            end
            EMIT_STATS:
            begin
                res_next.kind           = KIND_STATS;
                res_next.process_number = 5'(32'(pend_idx_reg) + 32'd1);
                res_next.finished       = rd_data_reg.done_flag;
                res_next.waiting_total  = rd_data_reg.wait_accum;
                res_next.turnaround     = sat_add32(rd_data_reg.wait_accum,
                                                    {16'd0, rd_data_reg.total_burst});
            end
            EMIT_STATS_NONE:
            begin
                res_next.kind = KIND_STATS;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            clock_reg     <= '0;
            quantum_reg   <= 16'd1;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            clock_reg     <= clock_next;
            found_reg     <= found_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
            if (quantum_we)
            begin
                quantum_reg <= quantum_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_ptr_reg <= scan_ptr_next;
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        run_reg      <= run_next;
        res_reg      <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

/* src/round_robin_slice_scheduler_core.sv */
// round_robin_slice_scheduler_core.sv: top level of the round-robin slice scheduler
// An item is taken when start is high and busy is low; its result, if any, appears
// on result for exactly one cycle with result_valid high, and the receiver cannot
// stall it. A load, a run on an empty table and a read of an unloaded slot answer
// in the cycle right after the accepting edge and leave busy low; clear produces no
// result. A read of a loaded slot holds busy while the entry is read and answers in
// the first cycle with busy low. A run on a loaded table scans the process table one
// slot per cycle through a registered read port, then runs ST_SCAN_TAIL, ST_UPD_START
// and, unless every loaded process has finished, ST_UPD_END and ST_UPD_WRITE; its
// result is on the ports in the first cycle with busy low. The user must write the
// quantum through quantum_we and quantum_data while idle; the block does not check.
module round_robin_slice_scheduler_core
    import rrss_pkg::*;
#(
    parameter int PROC_MAX = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  rrss_in_t    request,
    output logic        busy,
    input  logic        quantum_we,
    input  logic [15:0] quantum_data,
    output logic        result_valid,
    output rrss_out_t   result
);

    rrss_cmd_t    dp_cmd;
    rrss_status_t status;

    // sequencer
    rrss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (request.cmd),
        .status (status),
        .dp_cmd (dp_cmd),
        .busy   (busy)
    );

    // table and arithmetic
    rrss_datapath #(
        .PROC_MAX (PROC_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .quantum_we   (quantum_we),
        .quantum_data (quantum_data),
        .dp_cmd       (dp_cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    // a run on a non-empty table must occupy the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd == CMD_RUN && !status.count_zero) |=> busy)
        else $error("run item did not start a scan");

    // load and clear complete in the accepting cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.cmd == CMD_LOAD || request.cmd == CMD_CLEAR)) |=> !busy)
        else $error("load or clear item left the block busy");

    // a result only follows an accepted item or work in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy || start))
        else $error("result without an item");

    // a slice never ends before it starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_SLICE) |-> (result.slice_end >= result.slice_start))
        else $error("slice ends before it starts");
`endif

endmodule
